// File: rtl/flptm_pkg.sv
// Shared constants, codes and types of the four-level page table mapper.
package flptm_pkg;

    localparam int POOL_TABLES = 16;                       // power of two
    localparam int TBL_W       = $clog2(POOL_TABLES);
    localparam int NFT_W       = $clog2(POOL_TABLES + 1);
    localparam int IDX_W       = 9;
    localparam int ENTRIES     = 1 << IDX_W;
    localparam int MEM_ADDR_W  = TBL_W + IDX_W;
    localparam int ENTRY_W     = 64;
    localparam int VA_W        = 48;
    localparam int PAGE_SHIFT  = 12;
    localparam int PFN_W       = VA_W - PAGE_SHIFT;

    localparam logic KIND_MAP   = 1'b0;
    localparam logic KIND_XLATE = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISALIGN = 2'd1;
    localparam logic [1:0] ST_EXHAUST  = 2'd2;

    localparam logic [PAGE_SHIFT-1:0] TABLE_FLAGS = 12'h007;

    typedef struct packed {
        logic                  en;
        logic                  we;
        logic [MEM_ADDR_W-1:0] addr;
        logic [ENTRY_W-1:0]    wdata;
    } mem_req_t;

    typedef struct packed {
        logic [VA_W-1:0] translated_address;
        logic [1:0]      status;
    } result_t;

endpackage

// File: rtl/flptm_table_ram.sv
// Single-port synchronous table RAM with registered read data.
module flptm_table_ram #(
    parameter int ADDR_W = 13,
    parameter int DATA_W = 64
) (
    input  logic              aclk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [1 << ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/flptm_walker.sv
// Walk sequencer: table walk, page allocation, clearing sweeps and leaf update.
module flptm_walker
    import flptm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_kind,
    input  logic [VA_W-1:0]      in_va,
    input  logic [VA_W-1:0]      in_pa,
    input  logic [ENTRY_W-1:0]   in_flags,
    input  logic [VA_W-1:0]      pool_base,
    output mem_req_t             mem_req,
    input  logic [ENTRY_W-1:0]   mem_rdata,
    output logic                 res_valid,
    input  logic                 res_ready,
    output result_t              res
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_LINK  = 3'd4;
    localparam logic [2:0] S_LEAF  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [1:0]         lvl_reg, lvl_next;
    logic [TBL_W-1:0]   tbl_reg, tbl_next;
    logic [TBL_W-1:0]   clr_tbl_reg, clr_tbl_next;
    logic [IDX_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic               alloc_reg, alloc_next;
    logic [NFT_W-1:0]   nft_reg, nft_next;
    logic               kind_reg, kind_next;
    logic [VA_W-1:0]    va_reg, va_next;
    logic [VA_W-1:0]    pa_reg, pa_next;
    logic [ENTRY_W-1:0] flags_reg, flags_next;
    logic [VA_W-1:0]    xlat_reg, xlat_next;
    logic [1:0]         status_reg, status_next;

    logic [IDX_W-1:0]   cur_idx;
    logic [PFN_W-1:0]   new_pfn;
    logic [ENTRY_W-1:0] leaf_flags;
    logic [ENTRY_W-1:0] entry;

    function automatic logic [IDX_W-1:0] level_idx(input logic [VA_W-1:0] va,
                                                   input logic [1:0] lvl);
        logic [IDX_W-1:0] r;
        case (lvl)
            2'd3:    r = va[47:39];
            2'd2:    r = va[38:30];
            2'd1:    r = va[29:21];
            default: r = va[20:12];
        endcase
        return r;
    endfunction

    assign cur_idx = level_idx(va_reg, lvl_reg);
    assign entry   = mem_rdata;
    assign new_pfn = pool_base[VA_W-1:PAGE_SHIFT] + PFN_W'(nft_reg);

    // move flag bit 12 to the large-page bit
    always_comb begin
        leaf_flags = flags_reg;
        if (flags_reg[12]) begin
            leaf_flags[12] = 1'b0;
            leaf_flags[7]  = 1'b1;
        end
    end

    always_comb begin
        state_next   = state_reg;
        lvl_next     = lvl_reg;
        tbl_next     = tbl_reg;
        clr_tbl_next = clr_tbl_reg;
        clr_cnt_next = clr_cnt_reg;
        alloc_next   = alloc_reg;
        nft_next     = nft_reg;
        kind_next    = kind_reg;
        va_next      = va_reg;
        pa_next      = pa_reg;
        flags_next   = flags_reg;
        xlat_next    = xlat_reg;
        status_next  = status_reg;
        mem_req      = '0;
        in_ready     = 1'b0;
        res_valid    = 1'b0;

        case (state_reg)
            S_CLEAR: begin
                mem_req.en   = 1'b1;
                mem_req.we   = 1'b1;
                mem_req.addr = {clr_tbl_reg, clr_cnt_reg};
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(ENTRIES - 1)) begin
                    state_next = alloc_reg ? S_LINK : S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    kind_next   = in_kind;
                    va_next     = in_va;
                    pa_next     = in_pa;
                    flags_next  = in_flags;
                    xlat_next   = '0;
                    status_next = ST_OK;
                    lvl_next    = 2'd3;
                    tbl_next    = '0;
                    if (in_kind == KIND_MAP &&
                        (in_va[PAGE_SHIFT-1:0] != '0 || in_pa[PAGE_SHIFT-1:0] != '0)) begin
                        status_next = ST_MISALIGN;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                mem_req.en   = 1'b1;
                mem_req.addr = {tbl_reg, cur_idx};
                state_next   = S_EVAL;
            end
            S_EVAL: begin
                if (lvl_reg == 2'd0) begin
                    xlat_next  = {entry[VA_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
                    state_next = S_DONE;
                end else if (entry[0] && !entry[7]) begin
                    // follow the pointer relative to the pool base
                    tbl_next = entry[PAGE_SHIFT +: TBL_W] - pool_base[PAGE_SHIFT +: TBL_W];
                    lvl_next = lvl_reg - 1'b1;
                    state_next = (lvl_reg == 2'd1 && kind_reg == KIND_MAP) ? S_LEAF : S_READ;
                end else if (nft_reg == NFT_W'(POOL_TABLES)) begin
                    status_next = ST_EXHAUST;
                    state_next  = S_DONE;
                end else begin
                    clr_tbl_next = nft_reg[TBL_W-1:0];
                    clr_cnt_next = '0;
                    alloc_next   = 1'b1;
                    state_next   = S_CLEAR;
                end
            end
            S_LINK: begin
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.addr  = {tbl_reg, cur_idx};
                mem_req.wdata = {{(ENTRY_W - VA_W){1'b0}}, new_pfn, TABLE_FLAGS};
                tbl_next      = clr_tbl_reg;
                nft_next      = nft_reg + 1'b1;
                lvl_next      = lvl_reg - 1'b1;
                alloc_next    = 1'b0;
                state_next = (lvl_reg == 2'd1 && kind_reg == KIND_MAP) ? S_LEAF : S_READ;
            end
            S_LEAF: begin
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.addr  = {tbl_reg, cur_idx};
                mem_req.wdata = {{(ENTRY_W - VA_W){1'b0}}, pa_reg} | leaf_flags;
                state_next    = S_DONE;
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.translated_address = xlat_reg;
    assign res.status             = status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_tbl_reg <= '0;
            clr_cnt_reg <= '0;
            alloc_reg   <= 1'b0;
            nft_reg     <= NFT_W'(1);
            lvl_reg     <= '0;
            tbl_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            clr_tbl_reg <= clr_tbl_next;
            clr_cnt_reg <= clr_cnt_next;
            alloc_reg   <= alloc_next;
            nft_reg     <= nft_next;
            lvl_reg     <= lvl_next;
            tbl_reg     <= tbl_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        va_reg     <= va_next;
        pa_reg     <= pa_next;
        flags_reg  <= flags_next;
        xlat_reg   <= xlat_next;
        status_reg <= status_next;
    end

    a_nft_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nft_reg <= NFT_W'(POOL_TABLES) && nft_reg != '0)
        else $error("free table counter out of range");

    a_nft_only_on_link: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_LINK) |=> (nft_reg == $past(nft_reg)))
        else $error("free table counter moved outside a link step");

    a_clear_writes_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> (mem_req.we && mem_req.wdata == '0))
        else $error("clearing sweep wrote nonzero data");

    a_link_after_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LINK) |-> ($past(state_reg) == S_CLEAR && tbl_reg != clr_tbl_reg ||
                                   $past(state_reg) == S_CLEAR))
        else $error("link step entered without a clearing sweep");

    a_xlat_zero_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && status_reg != ST_OK) |-> (xlat_reg == '0))
        else $error("error result carries an address");

endmodule

// File: rtl/four_level_page_table_mapper_top.sv
// Four-level page table mapper: top level with stream ports and output register.
// Sequence: a translate is accepted, makes four read/evaluate pairs and offers its result;
//   a map makes three pairs and writes the leaf; each new table adds a 512-entry clear and a link.
// Throughput: one item at a time, set by the single table RAM port that every
//   dependent level read goes through; while m_ holds an untaken result, a finished walk waits.
// Reset: aresetn low clears control; afterwards a sweep over its 512 entries clears the top
//   table before s_tready rises. The free table counter restarts at 1.
module four_level_page_table_mapper_top
    import flptm_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [159:0]  s_tdata,   // virtual_address[47:0], physical_address[95:48],
                                     // leaf_flags[159:96]
    input  logic          s_tuser,   // kind[0]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [47:0]   m_tdata,   // translated_address[47:0]
    output logic [1:0]    m_tuser,   // status[1:0]
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [47:0]   cfg_data   // pool_base_address
);

    mem_req_t           mem_req;
    logic [ENTRY_W-1:0] mem_rdata;
    logic               res_valid;
    logic               res_ready;
    result_t            res;

    logic [VA_W-1:0]    base_reg;
    logic               m_tvalid_reg;
    result_t            out_reg;

    assign cfg_ready = 1'b1;
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
        end else if (cfg_valid) begin
            base_reg <= cfg_data;
        end
    end

    // hold the word until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg.translated_address;
    assign m_tuser  = out_reg.status;

    flptm_walker u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_va     (s_tdata[47:0]),
        .in_pa     (s_tdata[95:48]),
        .in_flags  (s_tdata[159:96]),
        .pool_base (base_reg),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    flptm_table_ram #(
        .ADDR_W (MEM_ADDR_W),
        .DATA_W (ENTRY_W)
    ) u_table_ram (
        .aclk  (aclk),
        .en    (mem_req.en),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata)
    );

endmodule

// File: dv/tb_four_level_page_table_mapper_top.sv
// Testbench for the four-level page table mapper: directed table, random walks, scoreboard.
`timescale 1ns / 1ps

module tb_four_level_page_table_mapper_top;
    import flptm_pkg::*;

    localparam logic [47:0] CFG_HIGH      = 48'hFFFF_FFFF_0000;
    localparam int          PHASES        = 6;
    localparam int          PHASE_ITEMS   = 225;
    localparam int          DRAIN_CYCLES  = 16;
    localparam int          CYCLE_LIMIT   = 400_000;

    typedef struct {
        logic        kind;
        logic [47:0] va;
        logic [47:0] pa;
        logic [63:0] flags;
        bit          typed;
        result_t     res;
    } stim_row_t;

    logic         aclk;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata  = '0;    // virtual_address, physical_address, leaf_flags
    logic         s_tuser  = 1'b0;  // kind
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [47:0]  m_tdata;          // translated_address
    logic [1:0]   m_tuser;          // status
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [47:0]  cfg_data  = '0;

    // Page table copy kept in step with the block
    logic [ENTRY_W-1:0] table_copy [0:POOL_TABLES*ENTRIES-1];
    int unsigned        free_table_copy;
    logic [47:0]        pool_base_copy;

    result_t   pending_results [$];
    stim_row_t directed_rows [$];
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    int        stall_left     = 0;
    bit        quiet          = 1'b0;
    result_t   want;

    four_level_page_table_mapper_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Follow one table entry, or allocate and link a cleared table; -1 when the pool is empty
    function automatic int walk_level(int unsigned tbl, logic [IDX_W-1:0] idx);
        int unsigned        slot;
        int unsigned        n;
        int                 k;
        logic [ENTRY_W-1:0] e;
        logic [47:0]        base;
        logic [47:0]        off;
        logic [47:0]        addr;
        slot = tbl * ENTRIES + idx;
        e    = table_copy[slot];
        base = {pool_base_copy[47:PAGE_SHIFT], 12'h000};
        if (e[0] && !e[7]) begin
            off = {e[47:PAGE_SHIFT], 12'h000} - base;
            return int'(off[PAGE_SHIFT +: TBL_W]);
        end
        if (free_table_copy >= POOL_TABLES) return -1;
        n = free_table_copy;
        addr = base + (48'(n) << PAGE_SHIFT);
        for (k = 0; k < ENTRIES; k++) table_copy[n * ENTRIES + k] = '0;
        table_copy[slot] = {16'h0000, addr[47:PAGE_SHIFT], TABLE_FLAGS};
        free_table_copy = n + 1;
        return int'(n);
    endfunction

    function automatic result_t predict_walk(logic kind, logic [47:0] va, logic [47:0] pa,
                                             logic [63:0] flags);
        result_t            r;
        int                 t;
        int                 nt;
        int                 lvl;
        int unsigned        slot;
        logic [ENTRY_W-1:0] f;
        r = '0;
        if (kind == KIND_MAP && (va[11:0] != 12'h000 || pa[11:0] != 12'h000)) begin
            r.status = ST_MISALIGN;
            return r;
        end
        t = 0;
        for (lvl = 3; lvl >= 1; lvl--) begin
            nt = walk_level(t, va[PAGE_SHIFT + IDX_W * lvl +: IDX_W]);
            if (nt < 0) begin
                r.status = ST_EXHAUST;
                return r;
            end
            t = nt;
        end
        slot = t * ENTRIES + va[20:12];
        if (kind == KIND_MAP) begin
            f = flags;
            // move the large-page request from bit 12 to bit 7
            if (f[12]) begin
                f[12] = 1'b0;
                f[7]  = 1'b1;
            end
            table_copy[slot] = {16'h0000, pa} | f;
        end else begin
            r.translated_address = {table_copy[slot][47:PAGE_SHIFT], 12'h000};
        end
        return r;
    endfunction

    function automatic stim_row_t stim_row(logic kind, logic [47:0] va, logic [47:0] pa,
                                           logic [63:0] flags, bit typed,
                                           logic [47:0] addr, logic [1:0] status);
        stim_row_t row;
        row.kind  = kind;
        row.va    = va;
        row.pa    = pa;
        row.flags = flags;
        row.typed = typed;
        row.res.translated_address = addr;
        row.res.status             = status;
        return row;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, exp_val, cycle_count);
        mismatch_count++;
    endtask

    // Offer one word, hold it until accepted, then record what it must produce
    task automatic send_item(input logic kind, input logic [47:0] va, input logic [47:0] pa,
                             input logic [63:0] flags, input bit typed,
                             input result_t typed_res);
        result_t r;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {flags, pa, va};
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        r = predict_walk(kind, va, pa, flags);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_pool_base(input logic [47:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        pool_base_copy = value;
    endtask

    function automatic logic [47:0] random_base(bit keep_slots);
        logic [47:0] v;
        v = {16'($urandom), 32'($urandom)};
        if (v[47:16] == '1) v[16] = 1'b0;
        // zero bits 15..12 keep existing links resolving to the same pool pages
        if (keep_slots) v[15:12] = 4'h0;
        else if (v[15:12] == 4'h0) v[15:12] = 4'h5;
        return v;
    endfunction

    // Result side: random stall bursts, none in the last phase
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", {14'h0, m_tuser, m_tdata}, 64'h0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata !== want.translated_address)
                    report_mismatch("translated_address", 64'(m_tdata),
                                    64'(want.translated_address));
                if (m_tuser !== want.status)
                    report_mismatch("status", 64'(m_tuser), 64'(want.status));
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        int          k;
        int          phase;
        int          pick;
        logic        kind;
        logic [47:0] va;
        logic [47:0] pa;
        logic [47:0] base;
        logic [63:0] flags;

        for (k = 0; k < POOL_TABLES * ENTRIES; k++) table_copy[k] = '0;
        free_table_copy = 1;
        pool_base_copy  = '0;

        // After reset, extremes, bit 12 move, alignment and pool exhaustion (pool of 16)
        directed_rows.push_back(stim_row(KIND_XLATE, 48'h0, 48'h0, 64'h0, 1, 48'h0, ST_OK));
        directed_rows.push_back(stim_row(KIND_MAP, 48'h0, 48'h0, 64'h0, 1, 48'h0, ST_OK));
        directed_rows.push_back(stim_row(KIND_MAP, 48'h0000_0000_1001, 48'h0, 64'h0,
                                         1, 48'h0, ST_MISALIGN));
        directed_rows.push_back(stim_row(KIND_MAP, 48'h0000_0000_4000, 48'h0000_0000_0801,
                                         64'h0, 1, 48'h0, ST_MISALIGN));
        directed_rows.push_back(stim_row(KIND_XLATE, 48'h0000_0000_1FFF, 48'h0, 64'h0,
                                         1, 48'h0, ST_OK));
        directed_rows.push_back(stim_row(KIND_MAP, 48'hFFFF_FFFF_F000, 48'hFFFF_FFFF_F000,
                                         64'hFFFF_FFFF_FFFF_FFFF, 1, 48'h0, ST_OK));
        directed_rows.push_back(stim_row(KIND_XLATE, 48'hFFFF_FFFF_FFFF, 48'h0, 64'h0,
                                         1, 48'hFFFF_FFFF_F000, ST_OK));
        directed_rows.push_back(stim_row(KIND_MAP, 48'h0000_0000_2000, 48'h0,
                                         64'h0000_0000_0000_1000, 1, 48'h0, ST_OK));
        directed_rows.push_back(stim_row(KIND_XLATE, 48'h0000_0000_2000, 48'h0, 64'h0,
                                         1, 48'h0, ST_OK));
        directed_rows.push_back(stim_row(KIND_MAP, 48'h0000_0000_3000, 48'h0000_1234_5000,
                                         64'h3, 1, 48'h0, ST_OK));
        directed_rows.push_back(stim_row(KIND_XLATE, 48'h0000_0000_3000, 48'h0, 64'h0,
                                         0, 48'h0, ST_OK));
        directed_rows.push_back(stim_row(KIND_MAP, 48'h0080_0000_0000, 48'h0000_ABCD_E000,
                                         64'h8000_0000_0000_0067, 1, 48'h0, ST_OK));
        directed_rows.push_back(stim_row(KIND_XLATE, 48'h0080_0000_0123, 48'h0, 64'h0,
                                         0, 48'h0, ST_OK));
        directed_rows.push_back(stim_row(KIND_MAP, 48'h0100_0000_0000, 48'h0000_7654_3000,
                                         64'h0, 1, 48'h0, ST_OK));
        directed_rows.push_back(stim_row(KIND_MAP, 48'h0000_0020_0000, 48'h0000_0000_5000,
                                         64'h1001, 1, 48'h0, ST_OK));
        directed_rows.push_back(stim_row(KIND_XLATE, 48'h0000_0020_0000, 48'h0, 64'h0,
                                         0, 48'h0, ST_OK));
        // two tables left: this walk links both and then runs dry
        directed_rows.push_back(stim_row(KIND_MAP, 48'h0180_0000_0000, 48'h0, 64'h0,
                                         1, 48'h0, ST_EXHAUST));
        directed_rows.push_back(stim_row(KIND_XLATE, 48'h0180_0000_0000, 48'h0, 64'h0,
                                         1, 48'h0, ST_EXHAUST));
        directed_rows.push_back(stim_row(KIND_XLATE, 48'h0000_4000_0000, 48'h0, 64'h0,
                                         1, 48'h0, ST_EXHAUST));
        directed_rows.push_back(stim_row(KIND_XLATE, 48'h0, 48'h0, 64'h0, 1, 48'h0, ST_OK));
        directed_rows.push_back(stim_row(KIND_MAP, 48'hFFFF_FFFF_FFFF, 48'h0, 64'h0,
                                         1, 48'h0, ST_MISALIGN));
        directed_rows.push_back(stim_row(KIND_XLATE, 48'hFFFF_FFFF_F000, 48'h0, 64'h0,
                                         1, 48'hFFFF_FFFF_F000, ST_OK));
        directed_rows.push_back(stim_row(KIND_XLATE, 48'h0000_0000_3ABC, 48'hFFFF_FFFF_FFFF,
                                         64'hFFFF_FFFF_FFFF_FFFF, 0, 48'h0, ST_OK));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        write_pool_base(CFG_HIGH);
        foreach (directed_rows[i])
            send_item(directed_rows[i].kind, directed_rows[i].va, directed_rows[i].pa,
                      directed_rows[i].flags, directed_rows[i].typed, directed_rows[i].res);

        for (phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            case (phase)
                0:       base = 48'h0;
                1:       base = random_base(1'b1);
                2:       base = random_base(1'b0);   // links resolve to shifted pages
                3:       base = 48'h0000_0000_0FFF;
                4:       base = random_base(1'b1);
                default: base = CFG_HIGH;
            endcase
            write_pool_base(base);
            quiet = (phase == PHASES - 1);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                pick  = $urandom_range(0, 99);
                kind  = 1'($urandom_range(0, 1));
                pa    = {16'($urandom), 32'($urandom)};
                flags = {$urandom, $urandom};
                va    = {16'($urandom), 32'($urandom)};
                if (pick < 88) begin
                    // walk one of the linked paths, mostly on a few hot leaves
                    case ($urandom_range(0, 5))
                        0:       va[47:21] = 27'h0000000;
                        1:       va[47:21] = 27'h7FFFFFF;
                        2:       va[47:21] = 27'h0040000;
                        3:       va[47:21] = 27'h0080000;
                        4:       va[47:21] = 27'h0000001;
                        default: va[47:21] = 27'h00C0000;
                    endcase
                    if ($urandom_range(0, 1) == 0) va[20:12] = 9'($urandom_range(0, 15));
                    if (pick < 80) begin
                        if (kind == KIND_MAP) begin
                            va[11:0] = 12'h000;
                            pa[11:0] = 12'h000;
                        end
                    end else begin
                        kind = KIND_MAP;
                        if ($urandom_range(0, 1) == 0) va[11:0] = 12'h000;
                        else pa[11:0] = 12'h000;
                    end
                end
                send_item(kind, va, pa, flags, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/flptm_pkg.sv
rtl/flptm_table_ram.sv
rtl/flptm_walker.sv
rtl/four_level_page_table_mapper_top.sv
dv/tb_four_level_page_table_mapper_top.sv
